// File: hdl/m3i_pkg.sv
package m3i_pkg;

  localparam int unsigned ELEM_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned NUM_ELEM       = 9;
  localparam int unsigned FRONT_STAGES   = 6;

  function automatic int unsigned max_u(input int unsigned a, input int unsigned b);
    return (a > b) ? a : b;
  endfunction

endpackage

// File: hdl/matrix3_inverse_unit.sv
// 3x3 matrix inverse by adjugate over determinant, signed fixed point
// (Q16.16 by default). One matrix is taken per cycle unless out_stall_i backs
// up a full pipeline; each result passes through six cofactor/determinant
// stages, a range-check stage plus one stage per quotient bit in each of nine
// parallel divider lanes, and the output register. Elements are truncated
// toward zero and saturated; a zero determinant gives singular and zeros.
module matrix3_inverse_unit import m3i_pkg::*; #(
  parameter int unsigned ELEM_WIDTH = ELEM_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [ELEM_WIDTH-1:0] in_r0_c0_i,
  input  logic signed [ELEM_WIDTH-1:0] in_r0_c1_i,
  input  logic signed [ELEM_WIDTH-1:0] in_r0_c2_i,
  input  logic signed [ELEM_WIDTH-1:0] in_r1_c0_i,
  input  logic signed [ELEM_WIDTH-1:0] in_r1_c1_i,
  input  logic signed [ELEM_WIDTH-1:0] in_r1_c2_i,
  input  logic signed [ELEM_WIDTH-1:0] in_r2_c0_i,
  input  logic signed [ELEM_WIDTH-1:0] in_r2_c1_i,
  input  logic signed [ELEM_WIDTH-1:0] in_r2_c2_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [ELEM_WIDTH-1:0] inv_r0_c0_o,
  output logic signed [ELEM_WIDTH-1:0] inv_r0_c1_o,
  output logic signed [ELEM_WIDTH-1:0] inv_r0_c2_o,
  output logic signed [ELEM_WIDTH-1:0] inv_r1_c0_o,
  output logic signed [ELEM_WIDTH-1:0] inv_r1_c1_o,
  output logic signed [ELEM_WIDTH-1:0] inv_r1_c2_o,
  output logic signed [ELEM_WIDTH-1:0] inv_r2_c0_o,
  output logic signed [ELEM_WIDTH-1:0] inv_r2_c1_o,
  output logic signed [ELEM_WIDTH-1:0] inv_r2_c2_o,
  output logic                         singular_o
);

  localparam int unsigned DW = 3 * ELEM_WIDTH + 3;
  localparam int unsigned NW = 2 * ELEM_WIDTH + 1 + 2 * FRAC_BITS;
  localparam int unsigned NS = FRONT_STAGES + ELEM_WIDTH + 1;

  logic signed [ELEM_WIDTH-1:0] elem [NUM_ELEM];
  logic [NW-1:0]                nmag [NUM_ELEM];
  logic [NUM_ELEM-1:0]          fneg;
  logic [DW-1:0]                dmag;
  logic                         fzero;
  logic [ELEM_WIDTH-2:0]        lq [NUM_ELEM];
  logic [NUM_ELEM-1:0]          lsat, lneg, lzero;
  logic signed [ELEM_WIDTH-1:0] res_q [NUM_ELEM];
  logic                         sing_q;
  logic [NS-1:0]                v_q, ld;

  assign elem[0] = in_r0_c0_i;
  assign elem[1] = in_r0_c1_i;
  assign elem[2] = in_r0_c2_i;
  assign elem[3] = in_r1_c0_i;
  assign elem[4] = in_r1_c1_i;
  assign elem[5] = in_r1_c2_i;
  assign elem[6] = in_r2_c0_i;
  assign elem[7] = in_r2_c1_i;
  assign elem[8] = in_r2_c2_i;

  // stage loads when empty or when its content moves on
  always_comb begin
    ld[NS-1] = !v_q[NS-1] || !out_stall_i;
    for (int k = NS - 2; k >= 0; k--) ld[k] = !v_q[k] || ld[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (ld[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) if (ld[k]) v_q[k] <= v_q[k-1];
    end
  end

  assign in_stall_o  = !ld[0];
  assign out_valid_o = v_q[NS-1];

  m3i_front #(.ELEM_WIDTH(ELEM_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i  (clk_i),
    .ld_i   (ld[FRONT_STAGES-1:0]),
    .elem_i (elem),
    .nmag_o (nmag),
    .neg_o  (fneg),
    .dmag_o (dmag),
    .zero_o (fzero)
  );

  // lane c divides cofactor c, which lands transposed in the result
  for (genvar c = 0; c < NUM_ELEM; c++) begin : g_lane
    localparam int unsigned T = (c % 3) * 3 + c / 3;
    logic [ELEM_WIDTH-1:0] qx;
    m3i_div_lane #(.ELEM_WIDTH(ELEM_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lane (
      .clk_i  (clk_i),
      .ld_i   (ld[FRONT_STAGES+ELEM_WIDTH-1:FRONT_STAGES]),
      .nmag_i (nmag[c]),
      .dmag_i (dmag),
      .neg_i  (fneg[c]),
      .zero_i (fzero),
      .q_o    (lq[c]),
      .sat_o  (lsat[c]),
      .neg_o  (lneg[c]),
      .zero_o (lzero[c])
    );
    assign qx = {1'b0, lq[c]};
    always_ff @(posedge clk_i) begin
      if (ld[NS-1]) begin
        if (lzero[c]) begin
          res_q[T] <= '0;
        end else if (lsat[c]) begin
          res_q[T] <= lneg[c] ? $signed({1'b1, {(ELEM_WIDTH-1){1'b0}}})
                              : $signed({1'b0, {(ELEM_WIDTH-1){1'b1}}});
        end else begin
          res_q[T] <= lneg[c] ? $signed(-qx) : $signed(qx);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[NS-1]) sing_q <= lzero[0];
  end

  assign inv_r0_c0_o = res_q[0];
  assign inv_r0_c1_o = res_q[1];
  assign inv_r0_c2_o = res_q[2];
  assign inv_r1_c0_o = res_q[3];
  assign inv_r1_c1_o = res_q[4];
  assign inv_r1_c2_o = res_q[5];
  assign inv_r2_c0_o = res_q[6];
  assign inv_r2_c1_o = res_q[7];
  assign inv_r2_c2_o = res_q[8];
  assign singular_o  = sing_q;

  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && singular_o |-> inv_r0_c0_o == '0 && inv_r1_c1_o == '0 &&
                                  inv_r2_c2_o == '0 && inv_r0_c2_o == '0)
    else $error("singular result with nonzero elements");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output side free");

  a_lane_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NS-2] |-> $countones(lzero) == 0 || $countones(lzero) == NUM_ELEM)
    else $error("lanes disagree on singular flag");

endmodule

// File: hdl/m3i_front.sv
// Cofactors, determinant and operand magnitudes, six register stages.
module m3i_front import m3i_pkg::*; #(
  parameter int unsigned ELEM_WIDTH = ELEM_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF,
  localparam int unsigned PW = 2 * ELEM_WIDTH,
  localparam int unsigned CFW = 2 * ELEM_WIDTH + 1,
  localparam int unsigned DW = 3 * ELEM_WIDTH + 3,
  localparam int unsigned NW = 2 * ELEM_WIDTH + 1 + 2 * FRAC_BITS
) (
  input  logic                         clk_i,
  input  logic [FRONT_STAGES-1:0]      ld_i,
  input  logic signed [ELEM_WIDTH-1:0] elem_i [NUM_ELEM],
  output logic [NW-1:0]                nmag_o [NUM_ELEM],
  output logic [NUM_ELEM-1:0]          neg_o,
  output logic [DW-1:0]                dmag_o,
  output logic                         zero_o
);

  logic signed [PW-1:0]         p1_q [NUM_ELEM];
  logic signed [PW-1:0]         p2_q [NUM_ELEM];
  logic signed [ELEM_WIDTH-1:0] e1_q [3];
  logic signed [ELEM_WIDTH-1:0] e2_q [3];
  logic signed [CFW-1:0]        cof2_q [NUM_ELEM];
  logic signed [CFW-1:0]        cof3_q [NUM_ELEM];
  logic signed [CFW-1:0]        cof4_q [NUM_ELEM];
  logic signed [CFW-1:0]        cof5_q [NUM_ELEM];
  logic signed [CFW-1:0]        ph_q [3];
  logic signed [CFW-1:0]        pl_q [3];
  logic signed [DW-1:0]         t_q [3];
  logic signed [DW-1:0]         det_q;

  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      localparam int unsigned C = i * 3 + j;
      localparam int unsigned A = ((i + 1) % 3) * 3 + (j + 1) % 3;
      localparam int unsigned B = ((i + 2) % 3) * 3 + (j + 2) % 3;
      localparam int unsigned X = ((i + 1) % 3) * 3 + (j + 2) % 3;
      localparam int unsigned Y = ((i + 2) % 3) * 3 + (j + 1) % 3;
      always_ff @(posedge clk_i) begin
        if (ld_i[0]) begin
          p1_q[C] <= PW'(elem_i[A]) * PW'(elem_i[B]);
          p2_q[C] <= PW'(elem_i[X]) * PW'(elem_i[Y]);
        end
        if (ld_i[1]) cof2_q[C] <= CFW'(p1_q[C]) - CFW'(p2_q[C]);
        if (ld_i[2]) cof3_q[C] <= cof2_q[C];
        if (ld_i[3]) cof4_q[C] <= cof3_q[C];
        if (ld_i[4]) cof5_q[C] <= cof4_q[C];
        if (ld_i[5]) begin
          nmag_o[C] <= NW'(cof5_q[C][CFW-1] ? $unsigned(-cof5_q[C]) : $unsigned(cof5_q[C]))
                       << (2 * FRAC_BITS);
          neg_o[C]  <= cof5_q[C][CFW-1] ^ det_q[DW-1];
        end
      end
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_det
    always_ff @(posedge clk_i) begin
      if (ld_i[0]) e1_q[j] <= elem_i[j];
      if (ld_i[1]) e2_q[j] <= e1_q[j];
      if (ld_i[2]) begin
        ph_q[j] <= CFW'(e2_q[j]) * CFW'($signed(cof2_q[j][CFW-1:ELEM_WIDTH]));
        pl_q[j] <= CFW'(e2_q[j]) * $signed(CFW'({1'b0, cof2_q[j][ELEM_WIDTH-1:0]}));
      end
      if (ld_i[3]) t_q[j] <= (DW'(ph_q[j]) <<< ELEM_WIDTH) + DW'(pl_q[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[4]) det_q <= t_q[0] + t_q[1] + t_q[2];
    if (ld_i[5]) begin
      dmag_o <= det_q[DW-1] ? $unsigned(-det_q) : $unsigned(det_q);
      zero_o <= (det_q == '0);
    end
  end

endmodule

// File: hdl/m3i_div_lane.sv
// Restoring divider, one stage for the range check and one per quotient bit.
module m3i_div_lane import m3i_pkg::*; #(
  parameter int unsigned ELEM_WIDTH = ELEM_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF,
  localparam int unsigned DW = 3 * ELEM_WIDTH + 3,
  localparam int unsigned NW = 2 * ELEM_WIDTH + 1 + 2 * FRAC_BITS,
  localparam int unsigned CW = max_u(NW, DW + ELEM_WIDTH)
) (
  input  logic                    clk_i,
  input  logic [ELEM_WIDTH-1:0]   ld_i,
  input  logic [NW-1:0]           nmag_i,
  input  logic [DW-1:0]           dmag_i,
  input  logic                    neg_i,
  input  logic                    zero_i,
  output logic [ELEM_WIDTH-2:0]   q_o,
  output logic                    sat_o,
  output logic                    neg_o,
  output logic                    zero_o
);

  logic [NW-1:0]         rem_q  [ELEM_WIDTH];
  logic [DW-1:0]         dmag_q [ELEM_WIDTH];
  logic [ELEM_WIDTH-2:0] q_q    [ELEM_WIDTH];
  logic                  sat_q  [ELEM_WIDTH];
  logic                  neg_q  [ELEM_WIDTH];
  logic                  zero_q [ELEM_WIDTH];

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      rem_q[0]  <= nmag_i;
      dmag_q[0] <= dmag_i;
      q_q[0]    <= '0;
      sat_q[0]  <= CW'(nmag_i) >= (CW'(dmag_i) << (ELEM_WIDTH - 1));
      neg_q[0]  <= neg_i;
      zero_q[0] <= zero_i;
    end
  end

  for (genvar k = 1; k < ELEM_WIDTH; k++) begin : g_stage
    localparam int unsigned B = ELEM_WIDTH - 1 - k;
    logic [CW-1:0]         den;
    logic                  ge;
    logic [ELEM_WIDTH-2:0] q_d;
    always_comb begin
      den    = CW'(dmag_q[k-1]) << B;
      ge     = CW'(rem_q[k-1]) >= den;
      q_d    = q_q[k-1];
      q_d[B] = ge;
    end
    always_ff @(posedge clk_i) begin
      if (ld_i[k]) begin
        rem_q[k]  <= ge ? NW'(CW'(rem_q[k-1]) - den) : rem_q[k-1];
        dmag_q[k] <= dmag_q[k-1];
        q_q[k]    <= q_d;
        sat_q[k]  <= sat_q[k-1];
        neg_q[k]  <= neg_q[k-1];
        zero_q[k] <= zero_q[k-1];
      end
    end
  end

  assign q_o    = q_q[ELEM_WIDTH-1];
  assign sat_o  = sat_q[ELEM_WIDTH-1];
  assign neg_o  = neg_q[ELEM_WIDTH-1];
  assign zero_o = zero_q[ELEM_WIDTH-1];

endmodule
